@@ hw/rtl/fpba_pkg.sv @@
// Shared types, codes and helpers for the fit-policy block allocator.
// Used by fpba_cell and fit_policy_block_allocator_top; no dependencies.
`timescale 1ns / 1ps

package fpba_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int SIZE_BITS_DEF  = 16;
  localparam int SUM_BITS       = 22;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  // input actions
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_REPORT  = 2'd2;
  localparam logic [1:0] ACT_RESTORE = 2'd3;

  // placement policies; code 3 behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // config register indexes
  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_LOAD,
    UPD_TAKE,
    UPD_RESTORE
  } upd_op_t;

  typedef struct packed {
    logic valid;
    logic report;
    logic found;
  } scan_ctl_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] internal_sum;
    logic [SUM_BITS-1:0] external_sum;
    logic [SUM_BITS-1:0] total_sum;
  } scan_sums_t;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [31:0] b);
    logic [32:0] s;
    s = 33'(a) + 33'(b);
    return (s > 33'(SUM_MAX)) ? SUM_MAX : s[SUM_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/fit_policy_block_allocator_top.sv @@
// Allocate and report scan the chain one cell per cycle: the beat passes the head register,
// each cell register in turn and the pending register before the output register takes the
// result. Load and restore go straight to the pending register, then the output register. One item
// is in flight at a time; an output stall holds the next beat until the result moves.
// Reset (rst, synchronous) clears config, marks and used total; sizes stay
// undefined until loaded. Depends on fpba_pkg and fpba_cell.
`timescale 1ns / 1ps

module fit_policy_block_allocator_top #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // action[1:0], block_index[7:2], size_kb[23:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // granted[0], chosen_block[6:1],
                                      // internal_frag[28:7], external_frag[50:29],
                                      // total_memory[72:51], used_memory[94:73], 0
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int BW = (CW > 7) ? CW : 7;
  localparam int SB = fpba_pkg::SUM_BITS;

  logic [1:0]           fit_policy;
  logic [6:0]           block_count;
  logic [BW-1:0]        bc_ext;
  logic [CW-1:0]        n_active;

  logic                 busy;
  logic [1:0]           cur_action;
  logic [5:0]           cur_index;
  logic [SIZE_BITS-1:0] cur_size;
  logic                 head_valid;
  logic                 head_report;

  logic                 pend_valid;
  logic                 pend_found;
  logic [IW-1:0]        pend_pick;
  fpba_pkg::scan_sums_t pend_sums;

  logic [SB-1:0]        used_total;
  logic [SB-1:0]        used_total_next;

  logic                 in_beat;
  logic                 drain;
  logic                 load_ok;
  fpba_pkg::upd_op_t    upd_op;
  logic [IW-1:0]        upd_idx;

  logic [1:0]           in_action;
  logic [SIZE_BITS-1:0] in_size;

  fpba_pkg::scan_ctl_t  chain_ctl  [MAX_BLOCKS+1];
  logic [IW-1:0]        chain_pick [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] chain_best [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] chain_req  [MAX_BLOCKS+1];
  fpba_pkg::scan_sums_t chain_sums [MAX_BLOCKS+1];

  assign in_action = s_axis_tdata[1:0];
  assign in_size   = SIZE_BITS'(s_axis_tdata[23:8]);

  assign bc_ext   = BW'(block_count);
  assign n_active = (bc_ext > BW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(bc_ext);

  assign s_axis_tready = !busy;
  assign in_beat       = s_axis_tvalid && !busy;
  assign drain         = pend_valid && (!m_axis_tvalid || m_axis_tready);
  assign load_ok       = (32'(cur_index) < 32'(MAX_BLOCKS));

  assign chain_ctl[0]  = '{valid: head_valid, report: head_report, found: 1'b0};
  assign chain_pick[0] = '0;
  assign chain_best[0] = '0;
  assign chain_req[0]  = cur_size;
  assign chain_sums[0] = '0;

  always_comb begin
    upd_op          = fpba_pkg::UPD_NONE;
    upd_idx         = pend_pick;
    used_total_next = used_total;
    if (drain) begin
      unique case (cur_action)
        fpba_pkg::ACT_LOAD: begin
          upd_idx = IW'(cur_index);
          if (load_ok) upd_op = fpba_pkg::UPD_LOAD;
        end
        fpba_pkg::ACT_ALLOC: begin
          if (pend_found) begin
            upd_op          = fpba_pkg::UPD_TAKE;
            used_total_next = fpba_pkg::sat_add(used_total, 32'(cur_size));
          end
        end
        fpba_pkg::ACT_RESTORE: begin
          upd_op          = fpba_pkg::UPD_RESTORE;
          used_total_next = '0;
        end
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      fpba_cell #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX        (g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .n_active (n_active),
        .policy   (fit_policy),
        .upd_op   (upd_op),
        .upd_idx  (upd_idx),
        .upd_size (cur_size),
        .ctl_in   (chain_ctl[g]),
        .pick_in  (chain_pick[g]),
        .best_in  (chain_best[g]),
        .req_in   (chain_req[g]),
        .sums_in  (chain_sums[g]),
        .ctl_out  (chain_ctl[g+1]),
        .pick_out (chain_pick[g+1]),
        .best_out (chain_best[g+1]),
        .req_out  (chain_req[g+1]),
        .sums_out (chain_sums[g+1])
      );
    end
  endgenerate

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= fpba_pkg::POL_FIRST;
      block_count   <= '0;
      busy          <= 1'b0;
      head_valid    <= 1'b0;
      head_report   <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      used_total    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          fpba_pkg::REG_FIT_POLICY:  fit_policy  <= cfg_wdata[1:0];
          fpba_pkg::REG_BLOCK_COUNT: block_count <= cfg_wdata;
          default: ;
        endcase
      end
      used_total <= used_total_next;
      head_valid <= 1'b0;
      if (in_beat) begin
        busy        <= 1'b1;
        head_report <= (in_action == fpba_pkg::ACT_REPORT);
        if (in_action == fpba_pkg::ACT_ALLOC || in_action == fpba_pkg::ACT_REPORT) begin
          head_valid <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
      end
      if (chain_ctl[MAX_BLOCKS].valid) begin
        pend_valid <= 1'b1;
      end
      if (drain) begin
        pend_valid    <= 1'b0;
        busy          <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_action <= in_action;
      cur_index  <= s_axis_tdata[7:2];
      cur_size   <= in_size;
      pend_found <= 1'b0;
      pend_pick  <= '0;
      pend_sums  <= '0;
    end
    if (chain_ctl[MAX_BLOCKS].valid) begin
      pend_found <= chain_ctl[MAX_BLOCKS].found && !chain_ctl[MAX_BLOCKS].report;
      pend_pick  <= chain_pick[MAX_BLOCKS];
      pend_sums  <= chain_sums[MAX_BLOCKS];
    end
    if (drain) begin
      if (cur_action == fpba_pkg::ACT_REPORT) begin
        m_axis_tdata <= {1'b0, used_total, pend_sums.total_sum,
                         pend_sums.external_sum, pend_sums.internal_sum, 6'd0, 1'b0};
      end else if (cur_action == fpba_pkg::ACT_ALLOC && pend_found) begin
        m_axis_tdata <= {1'b0, {(4*SB){1'b0}}, 6'(pend_pick), 1'b1};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/fpba_cell.sv @@
// One block slot of the allocator chain: holds sizes and mark, and
// updates the scan beat passing through it. Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_cell #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
  parameter int IDX        = 0,
  localparam int IW = $clog2(MAX_BLOCKS),
  localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CW-1:0]          n_active,
  input  logic [1:0]             policy,
  input  fpba_pkg::upd_op_t      upd_op,
  input  logic [IW-1:0]          upd_idx,
  input  logic [SIZE_BITS-1:0]   upd_size,
  input  fpba_pkg::scan_ctl_t    ctl_in,
  input  logic [IW-1:0]          pick_in,
  input  logic [SIZE_BITS-1:0]   best_in,
  input  logic [SIZE_BITS-1:0]   req_in,
  input  fpba_pkg::scan_sums_t   sums_in,
  output fpba_pkg::scan_ctl_t    ctl_out,
  output logic [IW-1:0]          pick_out,
  output logic [SIZE_BITS-1:0]   best_out,
  output logic [SIZE_BITS-1:0]   req_out,
  output fpba_pkg::scan_sums_t   sums_out
);

  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] orig;
  logic                 mark;

  logic                 active;
  logic                 take;
  logic                 hit;
  fpba_pkg::scan_ctl_t  ctl_next;
  logic [IW-1:0]        pick_next;
  logic [SIZE_BITS-1:0] best_next;
  fpba_pkg::scan_sums_t sums_next;

  assign active = (CW'(IDX) < n_active);
  assign hit    = (upd_idx == IW'(IDX));

  always_comb begin
    ctl_next  = ctl_in;
    pick_next = pick_in;
    best_next = best_in;
    sums_next = sums_in;
    take      = 1'b0;
    if (ctl_in.valid && active) begin
      if (ctl_in.report) begin
        sums_next.total_sum = fpba_pkg::sat_add(sums_in.total_sum, 32'(orig));
        if (mark) begin
          sums_next.internal_sum = fpba_pkg::sat_add(sums_in.internal_sum, 32'(rem));
        end else begin
          sums_next.external_sum = fpba_pkg::sat_add(sums_in.external_sum, 32'(rem));
        end
      end else if (rem >= req_in) begin
        if (!ctl_in.found) begin
          take = 1'b1;
        end else if (policy == fpba_pkg::POL_BEST) begin
          take = (rem < best_in);
        end else if (policy == fpba_pkg::POL_WORST) begin
          take = (rem > best_in);
        end
      end
    end
    if (take) begin
      ctl_next.found = 1'b1;
      pick_next      = IW'(IDX);
      best_next      = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
      mark    <= 1'b0;
    end else begin
      ctl_out <= ctl_next;
      unique case (upd_op)
        fpba_pkg::UPD_LOAD:    if (hit) mark <= 1'b0;
        fpba_pkg::UPD_TAKE:    if (hit) mark <= 1'b1;
        fpba_pkg::UPD_RESTORE: mark <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pick_out <= pick_next;
    best_out <= best_next;
    req_out  <= req_in;
    sums_out <= sums_next;
    unique case (upd_op)
      fpba_pkg::UPD_LOAD: begin
        if (hit) begin
          orig <= upd_size;
          rem  <= upd_size;
        end
      end
      fpba_pkg::UPD_TAKE:    if (hit) rem <= rem - upd_size;
      fpba_pkg::UPD_RESTORE: rem <= orig;
      default: ;
    endcase
  end

endmodule

@@ test/tb.sv @@
// Self-checking bench for fit_policy_block_allocator_top: random and directed beats,
// a scoreboard class that predicts placement, fragmentation and totals per request.
// Depends on fpba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] POL_ALIAS = 2'd3;   // unused policy code, behaves as first fit
  localparam int NBLK = 64;
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  block_index;
    logic [15:0] size_kb;
  } req_t;

  typedef struct packed {
    logic                          granted;
    logic [5:0]                    chosen_block;
    logic [fpba_pkg::SUM_BITS-1:0] internal_frag;
    logic [fpba_pkg::SUM_BITS-1:0] external_frag;
    logic [fpba_pkg::SUM_BITS-1:0] total_memory;
    logic [fpba_pkg::SUM_BITS-1:0] used_memory;
  } outcome_t;

  class alloc_scoreboard;
    logic [15:0]                   orig_kb[NBLK];
    logic [15:0]                   left_kb[NBLK];
    bit                            taken[NBLK];
    logic [fpba_pkg::SUM_BITS-1:0] used_kb;
    logic [1:0]                    policy;
    logic [6:0]                    count;
    outcome_t                      awaited[$];
    int errors, items, checked, grants, denials, reports;
    bit saturated;

    function new();
      for (int i = 0; i < NBLK; i++) begin
        orig_kb[i] = '0;
        left_kb[i] = '0;
        taken[i] = 0;
      end
      used_kb = '0;
      policy = fpba_pkg::POL_FIRST;
      count = '0;
    endfunction

    function void configure(logic addr, logic [6:0] val);
      if (addr == fpba_pkg::REG_FIT_POLICY) policy = val[1:0];
      else count = val;
    endfunction

    function logic [fpba_pkg::SUM_BITS-1:0] clip(longint v);
      return (v > longint'(fpba_pkg::SUM_MAX)) ? fpba_pkg::SUM_MAX
                                               : v[fpba_pkg::SUM_BITS-1:0];
    endfunction

    function outcome_t predict_outcome(req_t r);
      outcome_t o;
      int n;
      int pick;
      bit hit;
      longint inner, outer, whole;
      o = '0;
      n = (count > NBLK) ? NBLK : count;
      case (r.action)
        fpba_pkg::ACT_LOAD: begin
          orig_kb[r.block_index] = r.size_kb;
          left_kb[r.block_index] = r.size_kb;
          taken[r.block_index] = 0;
        end
        fpba_pkg::ACT_ALLOC: begin
          hit = 0;
          pick = 0;
          for (int i = 0; i < n; i++) begin
            if (left_kb[i] < r.size_kb) continue;
            if (!hit) begin
              hit = 1;
              pick = i;
              if (policy != fpba_pkg::POL_BEST && policy != fpba_pkg::POL_WORST) break;
            end else if (policy == fpba_pkg::POL_BEST && left_kb[i] < left_kb[pick]) begin
              pick = i;
            end else if (policy == fpba_pkg::POL_WORST && left_kb[i] > left_kb[pick]) begin
              pick = i;
            end
          end
          if (hit) begin
            left_kb[pick] = left_kb[pick] - r.size_kb;
            taken[pick] = 1;
            used_kb = clip(longint'(used_kb) + r.size_kb);
            o.granted = 1'b1;
            o.chosen_block = pick[5:0];
            grants++;
          end else begin
            denials++;
          end
        end
        fpba_pkg::ACT_REPORT: begin
          inner = 0;
          outer = 0;
          whole = 0;
          for (int i = 0; i < n; i++) begin
            whole += orig_kb[i];
            if (taken[i]) inner += left_kb[i];
            else outer += left_kb[i];
          end
          o.internal_frag = clip(inner);
          o.external_frag = clip(outer);
          o.total_memory = clip(whole);
          o.used_memory = used_kb;
          if (used_kb == fpba_pkg::SUM_MAX) saturated = 1;
          reports++;
        end
        default: begin
          for (int i = 0; i < NBLK; i++) begin
            left_kb[i] = orig_kb[i];
            taken[i] = 0;
          end
          used_kb = '0;
        end
      endcase
      return o;
    endfunction

    function void note_item(req_t r);
      awaited.push_back(predict_outcome(r));
      items++;
    endfunction

    function void field_cmp(string name, longint e, longint g);
      if (e != g) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited, actual %0h", $time, got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      field_cmp("granted", e.granted, got.granted);
      field_cmp("chosen_block", e.chosen_block, got.chosen_block);
      field_cmp("internal_frag", e.internal_frag, got.internal_frag);
      field_cmp("external_frag", e.external_frag, got.external_frag);
      field_cmp("total_memory", e.total_memory, got.total_memory);
      field_cmp("used_memory", e.used_memory, got.used_memory);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  alloc_scoreboard sb;
  bit calm = 0;
  int stall_left = 0;
  int quiet = 0;

  fit_policy_block_allocator_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic req_t mk(logic [1:0] act, logic [5:0] idx, logic [15:0] kb);
    req_t r;
    r.action = act;
    r.block_index = idx;
    r.size_kb = kb;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check on the beat, then decide the next ready level.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[28:7],
                       m_axis_tdata[50:29], m_axis_tdata[72:51], m_axis_tdata[94:73]});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && !rst && $urandom_range(0, 99) < 30) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles at %0t", quiet, $time);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {r.size_kb, r.block_index, r.action};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(r);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] pol, logic [6:0] cnt);
    cfg_we <= 1'b1;
    cfg_addr <= fpba_pkg::REG_FIT_POLICY;
    cfg_wdata <= {5'b0, pol};
    @(posedge clk);
    sb.configure(fpba_pkg::REG_FIT_POLICY, {5'b0, pol});
    cfg_addr <= fpba_pkg::REG_BLOCK_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    sb.configure(fpba_pkg::REG_BLOCK_COUNT, cnt);
    cfg_we <= 1'b0;
  endtask

  function automatic req_t random_item(int n);
    req_t r;
    int p;
    p = $urandom_range(0, 99);
    r.block_index = 6'($urandom_range(0, 63));
    r.size_kb = 16'($urandom);
    if (p < 45) begin
      r.action = fpba_pkg::ACT_ALLOC;
      case ($urandom_range(0, 9))
        0: r.size_kb = '0;
        1: r.size_kb = 16'hFFFF;
        2, 3, 4: if (n > 0) r.size_kb = sb.left_kb[$urandom_range(0, n - 1)];
        5, 6, 7: r.size_kb = 16'($urandom_range(0, 2000));
        default: ;
      endcase
    end else if (p < 65) begin
      r.action = fpba_pkg::ACT_REPORT;
    end else if (p < 88) begin
      r.action = fpba_pkg::ACT_LOAD;
      if (n > 0 && $urandom_range(0, 9) < 7) r.block_index = 6'($urandom_range(0, n - 1));
      case ($urandom_range(0, 9))
        0: r.size_kb = '0;
        1: r.size_kb = 16'hFFFF;
        2, 3, 4, 5: r.size_kb = 16'($urandom_range(0, 4000));
        default: ;
      endcase
    end else begin
      r.action = fpba_pkg::ACT_RESTORE;
    end
    return r;
  endfunction

  task automatic run_phase(logic [1:0] pol, logic [6:0] cnt, int len, bit no_gaps);
    int n;
    calm = no_gaps;
    set_config(pol, cnt);
    n = (cnt > NBLK) ? NBLK : cnt;
    repeat (len) send(random_item(n));
    settle();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every slot gets a size before any scan or restore can see it
    for (int i = 0; i < NBLK; i++) send(mk(fpba_pkg::ACT_LOAD, 6'(i), 16'($urandom)));

    // empty table: nothing fits, report is all zero
    send(mk(fpba_pkg::ACT_ALLOC, 0, 0));
    send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    settle();

    set_config(fpba_pkg::POL_FIRST, 4);
    send(mk(fpba_pkg::ACT_LOAD, 0, 100));
    send(mk(fpba_pkg::ACT_LOAD, 1, 16'hFFFF));
    send(mk(fpba_pkg::ACT_LOAD, 2, 0));
    send(mk(fpba_pkg::ACT_LOAD, 3, 100));
    send(mk(fpba_pkg::ACT_ALLOC, 0, 0));
    send(mk(fpba_pkg::ACT_ALLOC, 0, 60));
    send(mk(fpba_pkg::ACT_ALLOC, 0, 16'hFFFF));
    send(mk(fpba_pkg::ACT_ALLOC, 0, 16'hFFFF));
    send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    send(mk(fpba_pkg::ACT_RESTORE, 0, 0));
    send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    settle();

    // equal sizes in slots 0 and 3: tie goes low
    set_config(fpba_pkg::POL_BEST, 4);
    send(mk(fpba_pkg::ACT_ALLOC, 0, 50));
    send(mk(fpba_pkg::ACT_ALLOC, 0, 40));
    send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    settle();

    set_config(fpba_pkg::POL_WORST, 4);
    send(mk(fpba_pkg::ACT_ALLOC, 0, 1));
    send(mk(fpba_pkg::ACT_ALLOC, 0, 16'hFFFF));
    send(mk(fpba_pkg::ACT_ALLOC, 0, 0));
    send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    settle();

    set_config(POL_ALIAS, 127);
    send(mk(fpba_pkg::ACT_ALLOC, 0, 1));
    send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    send(mk(fpba_pkg::ACT_LOAD, 63, 16'hFFFF));
    send(mk(fpba_pkg::ACT_RESTORE, 0, 0));
    settle();

    run_phase(fpba_pkg::POL_FIRST, 64, 40, 0);
    run_phase(fpba_pkg::POL_BEST, 64, 40, 0);
    run_phase(fpba_pkg::POL_WORST, 127, 40, 1);
    run_phase(POL_ALIAS, 33, 40, 0);
    run_phase(fpba_pkg::POL_BEST, 1, 40, 0);
    run_phase(fpba_pkg::POL_WORST, 2, 40, 1);
    run_phase(fpba_pkg::POL_FIRST, 7'($urandom_range(1, 64)), 40, 0);
    run_phase(fpba_pkg::POL_BEST, 7'($urandom_range(65, 127)), 40, 0);

    // reload and regrant full-size blocks until the used total saturates
    calm = 0;
    set_config(fpba_pkg::POL_WORST, 64);
    send(mk(fpba_pkg::ACT_RESTORE, 0, 0));
    for (int k = 0; k < 70; k++) begin
      send(mk(fpba_pkg::ACT_LOAD, 6'(k % NBLK), 16'hFFFF));
      send(mk(fpba_pkg::ACT_ALLOC, 0, 16'hFFFF));
      if (k % 16 == 15) send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    end
    send(mk(fpba_pkg::ACT_REPORT, 0, 0));
    settle();

    repeat (NBLK + 8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("%0d requests, %0d results checked: %0d grants, %0d denials, %0d reports",
             sb.items, sb.checked, sb.grants, sb.denials, sb.reports);
    $display("all four policy codes, block counts from empty to above the table size,");
    $display("used total saturated: %0d", sb.saturated);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
